>>> rtl/assert_macros.svh
// Assertion helper macros for the monitor core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

>>> rtl/lpm_pkg.sv
// ----------------------------------------------------------------------------
// lpm_pkg: shared types and constants for the load protection monitor
// Request payloads, result payloads and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package lpm_pkg;
    typedef struct packed {
        logic        action;
        logic [16:0] voltage_mv;
        logic [15:0] current_ma;
        logic [3:0]  sink_zero_mask;
        logic        dac_in_transient;
    } lpm_in_t;

    typedef struct packed {
        logic [6:0]  fault_events;
        logic        no_regulation_status;
        logic        disable_request;
        logic [23:0] power_mw;
        logic [20:0] charge_mah;
        logic [20:0] energy_mwh;
    } lpm_out_t;

    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_SETPT = 3'd1;
    localparam logic [2:0] REG_TOL   = 3'd2;
    localparam logic [2:0] REG_OCL   = 3'd3;
    localparam logic [2:0] REG_OPL   = 3'd4;
    localparam logic [2:0] REG_FLOOR = 3'd5;
    localparam logic [2:0] REG_FMIN  = 3'd6;
    localparam logic [2:0] REG_TPS   = 3'd7;

    localparam logic [1:0] MODE_CC = 2'd0;
    localparam logic [1:0] MODE_CV = 2'd1;
    localparam logic [1:0] MODE_CR = 2'd2;
    localparam logic [1:0] MODE_CP = 2'd3;

    localparam logic [26:0] R_SAT = 27'd134217727;

    // Divider command: 33-bit dividend, 16-bit divisor
    typedef struct packed {
        logic        start;
        logic [32:0] dividend;
        logic [15:0] divisor;
    } lpm_div_req_t;

    typedef struct packed {
        logic        done;
        logic [32:0] quotient;
    } lpm_div_rsp_t;
endpackage
`default_nettype wire

>>> rtl/lpm_divider.sv
// ----------------------------------------------------------------------------
// lpm_divider: shared restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module lpm_divider (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lpm_pkg::lpm_div_req_t req,
    output lpm_pkg::lpm_div_rsp_t      rsp
);
    import lpm_pkg::*;

    logic [32:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[15:0], quo_reg[32]};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 6'd33;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, subtract where it fits
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[31:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[31:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule
`default_nettype wire

>>> rtl/load_protection_monitor_core.sv
// Sequence: a sample tick makes three passes through the shared divider
//   (resistance, charge rate, energy rate) plus steps for power, evaluate, two
//   hour scalings and output.
// Flow control: one request at a time; the next is taken the cycle after the result
//   is read.
// A restart tick clears the totals and goes straight to output, bypassing the divider.
// Reset: asynchronous, active low; control and configuration registers return to their
//   listed defaults, the payload registers are not reset.
// load_protection_monitor_core: per-tick protection and statistics monitor
// Power, regulation, fuse counters, discharge floor, charge and energy totals.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module load_protection_monitor_core #(
    parameter int NOREG_LIMIT = 10,
    parameter int FUSE_LIMIT  = 10,
    parameter int SINK_COUNT  = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire lpm_pkg::lpm_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output lpm_pkg::lpm_out_t      out_data,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [26:0]       cfg_data
);
    import lpm_pkg::*;

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PWR   = 4'd1;
    localparam logic [3:0] ST_RES   = 4'd2;
    localparam logic [3:0] ST_EVAL  = 4'd3;
    localparam logic [3:0] ST_CRATE = 4'd4;
    localparam logic [3:0] ST_ERATE = 4'd5;
    localparam logic [3:0] ST_CHR   = 4'd6;
    localparam logic [3:0] ST_ENR   = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;
    localparam logic [3:0] ST_WAIT  = 4'd9;
    localparam logic [3:0] ST_ENH   = 4'd10;

    localparam logic [7:0] NR_LIM = 8'(NOREG_LIMIT);
    localparam logic [7:0] FU_LIM = 8'(FUSE_LIMIT);
    localparam int         NS     = (SINK_COUNT < 4) ? SINK_COUNT : 4;

    // reciprocals: x/1000 = ((x>>3) * RCP_125) >> 37, x/3600 = ((x>>4) * RCP_225) >> 36
    localparam logic [30:0] RCP_125 = 31'd1099511628;
    localparam logic [30:0] RCP_225 = 31'd305419897;

    // configuration registers
    logic [1:0]  mode_reg;
    logic [26:0] setpt_reg, tol_reg;
    logic [15:0] ocl_reg, fmin_reg;
    logic [23:0] opl_reg;
    logic [16:0] floor_reg;
    logic [9:0]  tps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_CC;
            setpt_reg <= '0;
            tol_reg   <= 27'd100;
            ocl_reg   <= 16'hFFFF;
            opl_reg   <= 24'd8589934;
            floor_reg <= '0;
            fmin_reg  <= '0;
            tps_reg   <= 10'd10;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:  mode_reg  <= cfg_data[1:0];
                REG_SETPT: setpt_reg <= cfg_data;
                REG_TOL:   tol_reg   <= cfg_data;
                REG_OCL:   ocl_reg   <= cfg_data[15:0];
                REG_OPL:   opl_reg   <= cfg_data[23:0];
                REG_FLOOR: floor_reg <= cfg_data[16:0];
                REG_FMIN:  fmin_reg  <= cfg_data[15:0];
                REG_TPS:   tps_reg   <= cfg_data[9:0];
                default:   ;
            endcase
        end
    end

    lpm_div_req_t div_req;
    lpm_div_rsp_t div_rsp;

    lpm_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // control state
    logic [3:0]  st_reg, st_next;
    logic        started_reg, started_next;
    logic [7:0]  nrc_reg, nrc_next;
    logic        nrf_reg, nrf_next;
    logic [7:0]  fuse_reg [NS], fuse_next [NS];
    logic [31:0] chg_reg, chg_next, eng_reg, eng_next;
    // item payload
    lpm_in_t     item_reg, item_next;
    logic [32:0] prod_reg, prod_next;
    logic [23:0] pwr_reg, pwr_next;
    logic [26:0] meas_reg, meas_next;
    lpm_out_t    res_reg, res_next;
    // constant-divisor multiplier, product registered
    logic [29:0] mul_a;
    logic [30:0] mul_b;
    logic [60:0] mul_reg;

    logic [15:0] tps_div;
    logic [27:0] err;
    logic        oor;
    logic [8:0]  nrc_inc;
    logic [8:0]  fu_inc;

    assign tps_div = (tps_reg == '0) ? 16'd1 : {6'd0, tps_reg};

    always_comb
    begin
        st_next      = st_reg;
        started_next = 1'b0;
        nrc_next     = nrc_reg;
        nrf_next     = nrf_reg;
        fuse_next    = fuse_reg;
        chg_next     = chg_reg;
        eng_next     = eng_reg;
        item_next    = item_reg;
        prod_next    = prod_reg;
        pwr_next     = pwr_reg;
        meas_next    = meas_reg;
        res_next     = res_reg;
        div_req      = '0;
        mul_a        = '0;
        mul_b        = '0;
        err          = '0;
        oor          = 1'b0;
        nrc_inc      = '0;
        fu_inc       = '0;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_data;
                    if (in_data.action)
                    begin
                        // restart: clear totals, keep counters
                        chg_next = '0;
                        eng_next = '0;
                        res_next = '0;
                        res_next.no_regulation_status = nrf_reg;
                        st_next  = ST_OUT;
                    end
                    else
                    begin
                        prod_next = 33'(in_data.voltage_mv) * 33'(in_data.current_ma);
                        st_next   = ST_PWR;
                    end
                end
            end
            ST_PWR:
            begin
                // power in mW by reciprocal multiply of the product
                mul_a = prod_reg[32:3];
                mul_b = RCP_125;
                started_next = 1'b1;
                st_next = ST_RES;
            end
            ST_RES:
            begin
                // resistance v*1000/i, run always; used only in CR
                if (started_reg)
                begin
                    pwr_next         = mul_reg[60:37];
                    div_req.start    = 1'b1;
                    div_req.dividend = 33'(item_reg.voltage_mv) * 33'd1000;
                    div_req.divisor  = item_reg.current_ma;
                end
                else if (div_rsp.done)
                begin
                    meas_next = (item_reg.current_ma == '0) ? R_SAT
                                                             : div_rsp.quotient[26:0];
                    st_next   = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                unique case (mode_reg)
                    MODE_CC: meas_next = 27'(item_reg.current_ma);
                    MODE_CV: meas_next = 27'(item_reg.voltage_mv);
                    MODE_CR: meas_next = meas_reg;
                    MODE_CP: meas_next = 27'(pwr_reg);
                    default: meas_next = meas_reg;
                endcase
                err = ({1'b0, setpt_reg} >= {1'b0, meas_next})
                    ? {1'b0, setpt_reg} - {1'b0, meas_next}
                    : {1'b0, meas_next} - {1'b0, setpt_reg};
                oor = !(mode_reg == MODE_CC && item_reg.dac_in_transient)
                    && (err >= {1'b0, tol_reg});
                res_next = '0;
                res_next.fault_events[0] = item_reg.current_ma > ocl_reg;
                res_next.fault_events[1] = pwr_reg > opl_reg;
                if (oor)
                begin
                    nrc_inc = {1'b0, nrc_reg} + 9'd1;
                    nrc_next = nrc_inc[7:0];
                    if (nrc_inc[7:0] == NR_LIM)
                    begin
                        nrf_next = 1'b1;
                        res_next.fault_events[2] = 1'b1;
                        nrc_next = NR_LIM - 8'd1;
                    end
                end
                else
                begin
                    nrf_next = 1'b0;
                    if (nrc_reg != '0)
                        nrc_next = nrc_reg - 8'd1;
                end
                if (item_reg.current_ma > fmin_reg && !item_reg.dac_in_transient)
                begin
                    for (int s = 0; s < NS; s++)
                    begin
                        if (item_reg.sink_zero_mask[s])
                        begin
                            fu_inc = {1'b0, fuse_reg[s]} + 9'd1;
                            fuse_next[s] = fu_inc[7:0];
                            if (fu_inc[7:0] == FU_LIM)
                            begin
                                res_next.fault_events[3+s] = 1'b1;
                                fuse_next[s] = FU_LIM - 8'd1;
                            end
                        end
                        else if (fuse_reg[s] != '0)
                            fuse_next[s] = fuse_reg[s] - 8'd1;
                    end
                end
                res_next.no_regulation_status = nrf_next;
                res_next.disable_request = item_reg.voltage_mv < floor_reg;
                res_next.power_mw = pwr_reg;
                started_next = 1'b1;
                st_next = ST_CRATE;
            end
            ST_CRATE:
            begin
                if (started_reg)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = 33'(item_reg.current_ma);
                    div_req.divisor  = tps_div;
                end
                else if (div_rsp.done)
                begin
                    chg_next = chg_reg + div_rsp.quotient[31:0];
                    started_next = 1'b1;
                    st_next  = ST_ERATE;
                end
            end
            ST_ERATE:
            begin
                if (started_reg)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = 33'(pwr_reg);
                    div_req.divisor  = tps_div;
                end
                else if (div_rsp.done)
                begin
                    eng_next = eng_reg + div_rsp.quotient[31:0];
                    st_next  = ST_CHR;
                end
            end
            ST_CHR:
            begin
                // charge in hours: scale the total by 1/3600
                mul_a = {2'd0, chg_reg[31:4]};
                mul_b = RCP_225;
                st_next = ST_ENR;
            end
            ST_ENR:
            begin
                res_next.charge_mah = mul_reg[56:36];
                mul_a = {2'd0, eng_reg[31:4]};
                mul_b = RCP_225;
                st_next = ST_ENH;
            end
            ST_ENH:
            begin
                res_next.energy_mwh = mul_reg[56:36];
                st_next = ST_OUT;
            end
            ST_OUT:
            begin
                st_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (out_ready)
                    st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= ST_IDLE;
            started_reg <= 1'b0;
            nrc_reg     <= '0;
            nrf_reg     <= 1'b0;
            chg_reg     <= '0;
            eng_reg     <= '0;
            for (int s = 0; s < NS; s++)
                fuse_reg[s] <= '0;
        end
        else
        begin
            st_reg      <= st_next;
            started_reg <= started_next;
            nrc_reg     <= nrc_next;
            nrf_reg     <= nrf_next;
            chg_reg     <= chg_next;
            eng_reg     <= eng_next;
            fuse_reg    <= fuse_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        prod_reg <= prod_next;
        pwr_reg  <= pwr_next;
        meas_reg <= meas_next;
        res_reg  <= res_next;
        mul_reg  <= mul_a * mul_b;
    end

    assign in_ready  = (st_reg == ST_IDLE);
    assign out_valid = (st_reg == ST_WAIT);
    assign out_data  = res_reg;

    // a request is never taken while a result is held
    `CHK_IMPLY(a_no_overlap, clk, rst_n, out_valid, !in_ready)
    // the no-regulation counter stays below its limit
    `CHK_IMPLY(a_nrc_range, clk, rst_n, 1'b1, nrc_reg < NR_LIM)
    // a delivered result frees the input side next cycle
    `CHK_NEXT(a_release, clk, rst_n, out_valid && out_ready, in_ready)
endmodule
`default_nettype wire
